// ===== hw/rtl/rct_pkg.sv =====
package rct_pkg;

   // Command codes carried by the req_kind field.
   localparam logic [2:0] KIND_REGISTER      = 3'd0;
   localparam logic [2:0] KIND_REF_INSERT    = 3'd1;
   localparam logic [2:0] KIND_REF_EXISTING  = 3'd2;
   localparam logic [2:0] KIND_RELEASE       = 3'd3;
   localparam logic [2:0] KIND_COLLECT       = 3'd4;
   localparam logic [2:0] KIND_CLEAR         = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_FULL        = 2'd2;
   localparam logic [1:0] STATUS_PRESENT     = 2'd3;

   // A collect frees at most this many entries.
   localparam int MAX_RESULTS = 32;
   localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [31:0]        key;
      logic [31:0]        handle;
      logic [7:0]         routine;
      logic signed [15:0] count;
   } entry_type;

   typedef enum logic {
      CNT_INC = 1'b0,
      CNT_DEC = 1'b1
   } cnt_op_type;

   typedef struct packed {
      cnt_op_type         op;
      logic signed [15:0] value;
   } cnt_req_type;

   typedef struct packed {
      logic signed [15:0] sum;
      logic               sum_lt1;
      logic               value_lt1;
   } cnt_rsp_type;

endpackage

// ===== hw/rtl/rct_ram.sv =====
module rct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rct_cnt.sv =====
module rct_cnt import rct_pkg::*; (
   input  cnt_req_type req,
   output cnt_rsp_type rsp
);

   always_comb begin
      rsp.value_lt1 = (req.value < 16'sd1);
      unique case (req.op)
         CNT_INC: begin
            if (req.value == 16'sh7fff) begin
               rsp.sum = req.value;
            end else begin
               rsp.sum = req.value + 16'sd1;
            end
         end
         CNT_DEC: begin
            if (req.value == -16'sh8000) begin
               rsp.sum = req.value;
            end else begin
               rsp.sum = req.value - 16'sd1;
            end
         end
         default: begin
            rsp.sum = req.value;
         end
      endcase
      rsp.sum_lt1 = (rsp.sum < 16'sd1);
   end

endmodule

// ===== hw/rtl/reference_count_table_top.sv =====
// Reference counting table with sweep.
//
// Commands arrive on the req_ channel (valid/stall); each accepted item produces
// one or more result items on the rsp_ channel, the final one marked by rsp_last.
// Register, reference, reference-existing and release walk every table slot once
// to find the key and the lowest free slot: one slot per cycle through the entry
// memory's read port. ACT then applies the command and DONE moves the result
// into the output register, where it is presented; the block returns to idle
// as it does so, ready to take the next item.
// Collect walks the slots the same way, one result item per freed entry; clear
// and unknown kinds go straight to DONE, clear also emptying the table.
// The block works on one item at a time; req_stall is high while an item is in
// progress. A finished result sits in an output register, so the next item can be
// accepted while that result still waits to be taken.
// When the receiver holds rsp_stall high, the output register keeps its item and a
// collect sweep that finds another freed entry pauses in place until the pending result can move on.
// The collect_mode register is written on the csr_ channel, which is always ready;
// it must only be written while the block is idle.
// Reset empties the table and sets collect_mode to 1 (free entries on release).
// No clearing pass is needed: per-slot valid bits live in flip-flops.
module reference_count_table_top import rct_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic [31:0] req_handle,
   input  logic [7:0]  req_routine,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_freed,
   output logic [31:0] rsp_freed_key,
   output logic [31:0] rsp_freed_handle,
   output logic [7:0]  rsp_freed_routine,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_collect_mode
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SCAN_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [EMIT_W-1:0] EMIT_MAX = EMIT_W'(MAX_RESULTS);

   // Sequencer states. SCAN looks up a key, ACT applies the command, SWEEP runs a
   // collect, and DONE hands the final result to the output register.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_ACT   = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Latched command.
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] handle_ff, handle_in;
   logic [7:0]  routine_ff, routine_in;

   logic mode_ff, mode_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // Slot walk: scan_ff is the next address to read, cmp_* is the slot whose
   // memory data is visible this cycle.
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;

   // Lookup results.
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   entry_type         match_ff, match_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   logic [EMIT_W-1:0] emit_ff, emit_in;

   // Pending result. During a sweep it holds the most recently freed entry, which
   // cannot go out until it is known whether another one follows it.
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_freed_ff, res_freed_in;
   logic [31:0] res_key_ff, res_key_in;
   logic [31:0] res_handle_ff, res_handle_in;
   logic [7:0]  res_routine_ff, res_routine_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_freed_ff, rsp_freed_in;
   logic [31:0] rsp_key_ff, rsp_key_in;
   logic [31:0] rsp_handle_ff, rsp_handle_in;
   logic [7:0]  rsp_routine_ff, rsp_routine_in;
   logic        rsp_last_ff, rsp_last_in;

   // Memory and count unit hookup.
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type        rd_data, wr_data;
   cnt_req_type      cnt_req;
   cnt_rsp_type      cnt_rsp;

   logic out_free, issue, cand, hold;

   rct_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rct_cnt u_cnt (
      .req (cnt_req),
      .rsp (cnt_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      routine_in     = routine_ff;
      mode_in        = mode_ff;
      valid_in       = valid_ff;
      scan_in        = scan_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      match_idx_in   = match_idx_ff;
      match_in       = match_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      emit_in        = emit_ff;
      res_status_in  = res_status_ff;
      res_freed_in   = res_freed_ff;
      res_key_in     = res_key_ff;
      res_handle_in  = res_handle_ff;
      res_routine_in = res_routine_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_freed_in   = rsp_freed_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_routine_in = rsp_routine_ff;
      rsp_last_in    = rsp_last_ff;

      rd_en   = 1'b0;
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = match_idx_ff;
      wr_data = match_ff;

      cnt_req.op    = CNT_INC;
      cnt_req.value = match_ff.count;

      if (csr_valid) begin
         mode_in = csr_collect_mode;
      end

      // The output register frees up when its item is taken.
      out_free = !rsp_valid_ff || !rsp_stall;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      issue = (scan_ff < SCAN_END);
      cand  = 1'b0;
      hold  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in        = req_kind;
               key_in         = req_key;
               handle_in      = req_handle;
               routine_in     = req_routine;
               scan_in        = '0;
               cmp_vld_in     = 1'b0;
               found_in       = 1'b0;
               free_found_in  = 1'b0;
               emit_in        = '0;
               res_status_in  = STATUS_OK;
               res_freed_in   = 1'b0;
               res_key_in     = '0;
               res_handle_in  = '0;
               res_routine_in = '0;
               if (req_kind <= KIND_RELEASE) begin
                  state_in = ST_SCAN;
               end else if (req_kind == KIND_COLLECT) begin
                  state_in = ST_SWEEP;
               end else begin
                  if (req_kind == KIND_CLEAR) begin
                     valid_in = '0;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            rd_en = issue;
            if (issue) begin
               scan_in = scan_ff + SCAN_W'(1);
            end
            cmp_vld_in = issue;
            cmp_idx_in = scan_ff[IDX_W-1:0];
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && (rd_data.key == key_ff) && !found_ff) begin
                  found_in     = 1'b1;
                  match_idx_in = cmp_idx_ff;
                  match_in     = rd_data;
               end
               if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_ACT;
               end
            end
         end

         ST_ACT: begin
            cnt_req.op = (kind_ff == KIND_RELEASE) ? CNT_DEC : CNT_INC;
            wr_data.count = cnt_rsp.sum;
            unique case (kind_ff)
               KIND_REGISTER, KIND_REF_INSERT: begin
                  if (found_ff) begin
                     if (kind_ff == KIND_REGISTER) begin
                        res_status_in = STATUS_PRESENT;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end else if (free_found_ff) begin
                     wr_en           = 1'b1;
                     wr_addr         = free_idx_ff;
                     wr_data.key     = key_ff;
                     wr_data.handle  = handle_ff;
                     wr_data.routine = routine_ff;
                     wr_data.count   = (kind_ff == KIND_REGISTER) ? 16'sd0 : 16'sd1;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end
               KIND_REF_EXISTING: begin
                  if (found_ff) begin
                     wr_en = 1'b1;
                  end else begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
               end
               KIND_RELEASE: begin
                  if (found_ff) begin
                     wr_en = 1'b1;
                     if (mode_ff && cnt_rsp.sum_lt1) begin
                        valid_in[match_idx_ff] = 1'b0;
                        res_freed_in   = 1'b1;
                        res_key_in     = match_ff.key;
                        res_handle_in  = match_ff.handle;
                        res_routine_in = match_ff.routine;
                     end
                  end else begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end

         ST_SWEEP: begin
            cnt_req.op    = CNT_DEC;
            cnt_req.value = rd_data.count;
            cand = cmp_vld_ff && valid_ff[cmp_idx_ff] && cnt_rsp.value_lt1 &&
                   (emit_ff < EMIT_MAX);
            // A new candidate pushes the previous one out; wait if the output
            // register is still occupied. The memory read data holds meanwhile.
            hold = cand && res_freed_ff && !out_free;
            if (!hold) begin
               rd_en = issue;
               if (issue) begin
                  scan_in = scan_ff + SCAN_W'(1);
               end
               cmp_vld_in = issue;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               if (cand) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  if (res_freed_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = res_status_ff;
                     rsp_freed_in   = res_freed_ff;
                     rsp_key_in     = res_key_ff;
                     rsp_handle_in  = res_handle_ff;
                     rsp_routine_in = res_routine_ff;
                     rsp_last_in    = 1'b0;
                  end
                  res_status_in  = STATUS_OK;
                  res_freed_in   = 1'b1;
                  res_key_in     = rd_data.key;
                  res_handle_in  = rd_data.handle;
                  res_routine_in = rd_data.routine;
                  emit_in        = emit_ff + EMIT_W'(1);
               end
               if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_freed_in   = res_freed_ff;
               rsp_key_in     = res_key_ff;
               rsp_handle_in  = res_handle_ff;
               rsp_routine_in = res_routine_ff;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b1;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      routine_ff     <= routine_in;
      scan_ff        <= scan_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      match_idx_ff   <= match_idx_in;
      match_ff       <= match_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      emit_ff        <= emit_in;
      res_status_ff  <= res_status_in;
      res_freed_ff   <= res_freed_in;
      res_key_ff     <= res_key_in;
      res_handle_ff  <= res_handle_in;
      res_routine_ff <= res_routine_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_routine_ff <= rsp_routine_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_freed         = rsp_freed_ff;
   assign rsp_freed_key     = rsp_key_ff;
   assign rsp_freed_handle  = rsp_handle_ff;
   assign rsp_freed_routine = rsp_routine_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
